>>> src/hfse_pkg.sv
// ----------------------------------------------------------------------------
// hfse_pkg
// Shared types, constants and control words for the HSV fade slot engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hfse_pkg;

  // slot table size
  localparam int NumSlots = 8;
  localparam int SlotW    = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // hue circle and blink timing
  localparam logic signed [12:0] HueHalf  = 13'sd768;
  localparam logic signed [12:0] HueFull  = 13'sd1536;
  localparam int                 BlinkBit = 5;

  // divider geometry: 16-bit count times 11-bit delta magnitude
  localparam int ProdW    = 27;
  localparam int DivSteps = ProdW;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_DIRECT  = 2'd0,
    MODE_BLINK   = 2'd1,
    MODE_SMOOTH  = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_REVERSE  = 2'd1,
    ACT_RETARGET = 2'd2,
    ACT_FILL     = 2'd3
  } act_e;

  // channel selector for the shared divider
  typedef enum logic [1:0] {
    CH_HUE = 2'd0,
    CH_SAT = 2'd1,
    CH_VAL = 2'd2,
    CH_UNUSED = 2'd3
  } chan_e;

  typedef struct packed {
    logic [10:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } hsv_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  fade_mode;
    logic [7:0]  position;
    logic [1:0]  target_kind;
    hsv_t        start_color;
    hsv_t        end_color;
    logic [15:0] steps;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  slot_index;
    logic [7:0]  out_position;
    logic [1:0]  out_target_kind;
    logic [10:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
    logic        last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic find;
    logic apply;
    logic tick_start;
    logic next_slot;
    logic div_start;
    logic div_capture;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       slot_active;
    logic       slot_smooth;
    logic       ptr_last;
    logic       div_done;
    logic       sel_last;
    logic       out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/hfse_in_if.sv
// ----------------------------------------------------------------------------
// hfse_in_if
// Input channel: valid/ready handshake with one fade command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hfse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  fade_mode;
  logic [7:0]  position;
  logic [1:0]  target_kind;
  logic [10:0] start_hue;
  logic [7:0]  start_sat;
  logic [7:0]  start_val;
  logic [10:0] end_hue;
  logic [7:0]  end_sat;
  logic [7:0]  end_val;
  logic [15:0] steps;

  modport source (
    output valid, operation, fade_mode, position, target_kind,
    output start_hue, start_sat, start_val, end_hue, end_sat, end_val, steps,
    input  ready
  );
  modport sink (
    input  valid, operation, fade_mode, position, target_kind,
    input  start_hue, start_sat, start_val, end_hue, end_sat, end_val, steps,
    output ready
  );
endinterface

`default_nettype wire

>>> src/hfse_out_if.sv
// ----------------------------------------------------------------------------
// hfse_out_if
// Output channel: valid/ready handshake with one slot color word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hfse_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  slot_index;
  logic [7:0]  out_position;
  logic [1:0]  out_target_kind;
  logic [10:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;
  logic        last;

  modport source (
    output valid, slot_index, out_position, out_target_kind,
    output hue, saturation, brightness, last,
    input  ready
  );
  modport sink (
    input  valid, slot_index, out_position, out_target_kind,
    input  hue, saturation, brightness, last,
    output ready
  );
endinterface

`default_nettype wire

>>> src/hfse_div.sv
// ----------------------------------------------------------------------------
// hfse_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hfse_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [hfse_pkg::ProdW-1:0] dividend_i,
  input  wire logic [15:0]               divisor_i,
  output logic                           done_o,
  output logic [hfse_pkg::ProdW-1:0]     quotient_o
);
  import hfse_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [15:0]        rem_q, rem_d;
  logic [ProdW-1:0]   quo_q, quo_d;
  logic [15:0]        dsr_q, dsr_d;
  logic [16:0]        shifted;
  logic [16:0]        trial;

  // one restoring step
  always_comb begin
    shifted = {rem_q, quo_q[ProdW-1]};
    trial   = shifted - {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = trial[15:0];
        quo_d = {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = shifted[15:0];
        quo_d = {quo_q[ProdW-2:0], 1'b0};
      end
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> src/hfse_datapath.sv
// ----------------------------------------------------------------------------
// hfse_datapath
// Slot table, add search, color computation and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module hfse_datapath (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire hfse_pkg::in_word_t     in_word_i,
  input  wire hfse_pkg::ctrl_cmd_t    cmd_i,
  output hfse_pkg::dp_status_t        status_o,
  output hfse_pkg::out_word_t         out_word_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i
);
  import hfse_pkg::*;

  // slot table
  logic [1:0]  mode_q [NumSlots];
  logic [7:0]  pos_q  [NumSlots];
  logic [1:0]  kind_q [NumSlots];
  hsv_t        cur_q  [NumSlots];
  hsv_t        from_q [NumSlots];
  hsv_t        to_q   [NumSlots];
  logic [15:0] len_q  [NumSlots];
  logic [15:0] cnt_q  [NumSlots];

  in_word_t         in_q;
  logic [SlotW-1:0] ptr_q;
  act_e             act_q;
  chan_e            sel_q;
  logic             neg_q;
  hsv_t             last_c_q;
  hsv_t             smooth_q;
  out_word_t        out_q;
  logic             out_valid_q;

  // per-slot flags
  logic [NumSlots-1:0] running;
  logic [NumSlots-1:0] active;
  logic [NumSlots-1:0] match;

  always_comb begin
    for (int k = 0; k < NumSlots; k++) begin
      running[k] = (cnt_q[k] != len_q[k]);
      active[k]  = (cnt_q[k] < len_q[k]);
      match[k]   = (pos_q[k] == in_q.position) && (kind_q[k] == in_q.target_kind);
    end
  end

  // add search: reverse mode reverses the first match; else retarget running match, else fill
  logic             found;
  logic [SlotW-1:0] find_idx;
  act_e             find_act;

  always_comb begin
    found    = 1'b0;
    find_idx = '0;
    find_act = ACT_NONE;
    if (mode_e'(in_q.fade_mode) == MODE_REVERSE) begin
      for (int k = 0; k < NumSlots; k++) begin
        if (!found && match[k]) begin
          found    = 1'b1;
          find_idx = SlotW'(k);
          find_act = ACT_REVERSE;
        end
      end
    end else begin
      for (int k = 0; k < NumSlots; k++) begin
        if (!found && match[k] && running[k]) begin
          found    = 1'b1;
          find_idx = SlotW'(k);
          find_act = ACT_RETARGET;
        end
      end
      for (int k = 0; k < NumSlots; k++) begin
        if (!found && !running[k]) begin
          found    = 1'b1;
          find_idx = SlotW'(k);
          find_act = ACT_FILL;
        end
      end
    end
  end

  // current slot view
  hsv_t        f_c, t_c;
  logic [15:0] cnt_c, len_c;
  assign f_c   = from_q[ptr_q];
  assign t_c   = to_q[ptr_q];
  assign cnt_c = cnt_q[ptr_q];
  assign len_c = len_q[ptr_q];

  // divider operands for the selected channel
  logic signed [11:0] delta;
  logic        [11:0] mag;
  logic [ProdW-1:0]   prod;

  always_comb begin
    case (sel_q)
      CH_HUE: begin
        delta = $signed({1'b0, t_c.hue}) - $signed({1'b0, f_c.hue});
        if (delta > 12'(HueHalf)) begin
          delta = delta - 12'(HueFull);
        end else if (delta < -12'(HueHalf)) begin
          delta = delta + 12'(HueFull);
        end
      end
      CH_SAT:  delta = $signed({4'b0, t_c.sat}) - $signed({4'b0, f_c.sat});
      CH_VAL:  delta = $signed({4'b0, t_c.val}) - $signed({4'b0, f_c.val});
      default: delta = '0;
    endcase
    mag  = delta[11] ? 12'(-delta) : 12'(delta);
    prod = ProdW'(cnt_c * mag[10:0]);
  end

  logic             div_done;
  logic [ProdW-1:0] div_quo;

  hfse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod),
    .divisor_i  (len_c),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // signed quotient and channel sums
  logic signed [12:0] q_s;
  logic signed [12:0] hv;

  always_comb begin
    q_s = neg_q ? -$signed({1'b0, div_quo[11:0]}) : $signed({1'b0, div_quo[11:0]});
    hv  = $signed({2'b0, f_c.hue}) + q_s;
    if (hv < 13'sd0) begin
      hv = hv + HueFull;
    end else if (hv >= HueFull) begin
      hv = hv - HueFull;
    end
  end

  // color of the current slot for this tick
  hsv_t emit_c;
  always_comb begin
    case (mode_e'(mode_q[ptr_q]))
      MODE_DIRECT:  emit_c = (cnt_c < (len_c >> 1)) ? f_c : t_c;
      MODE_BLINK:   emit_c = cnt_c[BlinkBit] ? t_c : f_c;
      MODE_SMOOTH:  emit_c = smooth_q;
      default:      emit_c = last_c_q;
    endcase
  end

  // any later slot still to report in this tick
  logic later;
  always_comb begin
    later = 1'b0;
    for (int k = 0; k < NumSlots; k++) begin
      if (SlotW'(k) > ptr_q && active[k]) later = 1'b1;
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // slot table update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSlots; k++) begin
        mode_q[k] <= '0;
        pos_q[k]  <= '0;
        kind_q[k] <= '0;
        cur_q[k]  <= '0;
        from_q[k] <= '0;
        to_q[k]   <= '0;
        len_q[k]  <= '0;
        cnt_q[k]  <= '0;
      end
    end else begin
      if (cmd_i.apply) begin
        if (op_e'(in_q.operation) == OP_CLEAR) begin
          for (int k = 0; k < NumSlots; k++) cnt_q[k] <= len_q[k];
        end else begin
          case (act_q)
            ACT_REVERSE: begin
              cur_q[ptr_q]  <= to_q[ptr_q];
              to_q[ptr_q]   <= from_q[ptr_q];
              from_q[ptr_q] <= to_q[ptr_q];
              cnt_q[ptr_q]  <= '0;
            end
            ACT_RETARGET: begin
              mode_q[ptr_q] <= in_q.fade_mode;
              from_q[ptr_q] <= cur_q[ptr_q];
              to_q[ptr_q]   <= in_q.end_color;
              len_q[ptr_q]  <= in_q.steps;
              cnt_q[ptr_q]  <= '0;
            end
            ACT_FILL: begin
              mode_q[ptr_q] <= in_q.fade_mode;
              pos_q[ptr_q]  <= in_q.position;
              kind_q[ptr_q] <= in_q.target_kind;
              cur_q[ptr_q]  <= in_q.start_color;
              from_q[ptr_q] <= in_q.start_color;
              to_q[ptr_q]   <= in_q.end_color;
              len_q[ptr_q]  <= in_q.steps;
              cnt_q[ptr_q]  <= '0;
            end
            default: ;
          endcase
        end
      end else if (cmd_i.emit) begin
        cur_q[ptr_q] <= emit_c;
        cnt_q[ptr_q] <= cnt_c + 16'd1;
      end
    end
  end

  // walk and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      act_q       <= ACT_NONE;
      sel_q       <= CH_HUE;
      last_c_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.find) begin
        ptr_q <= find_idx;
        act_q <= find_act;
      end
      if (cmd_i.tick_start) begin
        ptr_q    <= '0;
        sel_q    <= CH_HUE;
        last_c_q <= '0;
      end
      if (cmd_i.next_slot) begin
        ptr_q <= ptr_q + 1'b1;
        sel_q <= CH_HUE;
      end
      if (cmd_i.div_capture) begin
        sel_q <= chan_e'(sel_q + 2'd1);
      end
      if (cmd_i.emit) begin
        last_c_q    <= emit_c;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) in_q <= in_word_i;
    if (cmd_i.div_start) neg_q <= delta[11];
    if (cmd_i.div_capture) begin
      case (sel_q)
        CH_HUE:  smooth_q.hue <= hv[10:0];
        CH_SAT:  smooth_q.sat <= f_c.sat + q_s[7:0];
        CH_VAL:  smooth_q.val <= f_c.val + q_s[7:0];
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      out_q.slot_index      <= 3'(ptr_q);
      out_q.out_position    <= pos_q[ptr_q];
      out_q.out_target_kind <= kind_q[ptr_q];
      out_q.hue             <= emit_c.hue;
      out_q.saturation      <= emit_c.sat;
      out_q.brightness      <= emit_c.val;
      out_q.last            <= !later;
    end
  end

  assign status_o.op          = in_q.operation;
  assign status_o.slot_active = active[ptr_q];
  assign status_o.slot_smooth = (mode_e'(mode_q[ptr_q]) == MODE_SMOOTH);
  assign status_o.ptr_last    = (ptr_q == SlotW'(NumSlots - 1));
  assign status_o.div_done    = div_done;
  assign status_o.sel_last    = (sel_q == CH_VAL);
  assign status_o.out_free    = out_free;

  assign out_word_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> src/hfse_ctrl.sv
// ----------------------------------------------------------------------------
// hfse_ctrl
// Sequencer: decodes a command word and walks the slots on a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module hfse_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire hfse_pkg::dp_status_t  status_i,
  output hfse_pkg::ctrl_cmd_t        cmd_o
);
  import hfse_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_DISPATCH  = 8'b0000_0010,
    ST_FIND      = 8'b0000_0100,
    ST_APPLY     = 8'b0000_1000,
    ST_SCAN      = 8'b0001_0000,
    ST_DIV_START = 8'b0010_0000,
    ST_DIV_WAIT  = 8'b0100_0000,
    ST_EMIT      = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (op_e'(status_i.op))
          OP_ADD:   state_d = ST_FIND;
          OP_CLEAR: state_d = ST_APPLY;
          OP_TICK: begin
            cmd_o.tick_start = 1'b1;
            state_d          = ST_SCAN;
          end
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_FIND: begin
        cmd_o.find = 1'b1;
        state_d    = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_SCAN: begin
        if (status_i.slot_active) begin
          state_d = status_i.slot_smooth ? ST_DIV_START : ST_EMIT;
        end else if (status_i.ptr_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.next_slot = 1'b1;
        end
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_capture = 1'b1;
          state_d           = status_i.sel_last ? ST_EMIT : ST_DIV_START;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.ptr_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next_slot = 1'b1;
            state_d         = ST_SCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> src/hsv_fade_slot_engine.sv
// ----------------------------------------------------------------------------
// hsv_fade_slot_engine
// Table of eight HSV fade slots: add, clear and tick words in, slot colors out.
// ----------------------------------------------------------------------------
// One word is taken at a time. Add words pass through dispatch, find and
// apply states; clear words through dispatch and apply. A tick word walks
// idle slots one per cycle; a direct or blink slot then goes to emit, and a
// smooth slot first runs the shared bit-serial divider three times (hue,
// saturation, value). Emit waits while the output is stalled. The last
// color word of a tick carries last set; a tick with no running slot gives no
// words. The output word is registered, so the next input word is taken while
// the final color of a tick waits to be read.
`default_nettype none

module hsv_fade_slot_engine (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hfse_in_if.sink     in_i,
  hfse_out_if.source  out_o
);
  import hfse_pkg::*;

  in_word_t   in_word;
  out_word_t  out_word;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       out_valid;

  // gather input fields
  assign in_word.operation       = in_i.operation;
  assign in_word.fade_mode       = in_i.fade_mode;
  assign in_word.position        = in_i.position;
  assign in_word.target_kind     = in_i.target_kind;
  assign in_word.start_color.hue = in_i.start_hue;
  assign in_word.start_color.sat = in_i.start_sat;
  assign in_word.start_color.val = in_i.start_val;
  assign in_word.end_color.hue   = in_i.end_hue;
  assign in_word.end_color.sat   = in_i.end_sat;
  assign in_word.end_color.val   = in_i.end_val;
  assign in_word.steps           = in_i.steps;

  hfse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hfse_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_word_o  (out_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready)
  );

  // drive output channel
  assign out_o.valid           = out_valid;
  assign out_o.slot_index      = out_word.slot_index;
  assign out_o.out_position    = out_word.out_position;
  assign out_o.out_target_kind = out_word.out_target_kind;
  assign out_o.hue             = out_word.hue;
  assign out_o.saturation      = out_word.saturation;
  assign out_o.brightness      = out_word.brightness;
  assign out_o.last            = out_word.last;

endmodule

`default_nettype wire
